/* hw/rtl/vcgs_pkg.sv */
// Shared constants, types and command codes for the Verlet cloth grid stepper.
// Used by the controller, the datapath and the top level.
`default_nettype none

package vcgs_pkg;

  // Grid geometry
  localparam int GRID_SIDE = 4;
  localparam int NODES     = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W     = $clog2(NODES);
  localparam int RC_W      = $clog2(GRID_SIDE);

  // Q16.16 constants
  localparam logic [31:0] REST_Q     = 32'd98304;   // 1.5
  localparam logic [32:0] GRAV_Q     = 33'd642253;  // 9.8
  localparam logic [31:0] DIST_MIN_Q = 32'd6;       // 1e-4
  localparam logic [16:0] ONE_Q      = 17'd65536;   // 1.0

  // Iterative units
  localparam int ITR_W    = 5;
  localparam int SQ_STEPS = 32;  // one result bit per cycle
  localparam int DV_STEPS = 30;  // quotient stays below 2^29

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  typedef struct packed {
    logic [3:0]         node_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_node;
  } node_res_t;

  typedef enum logic [0:0] {
    REG_CHARGE_BASE  = 1'b0,
    REG_CHARGE_RATIO = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DT2,
    ST_N_RD, ST_N_ACC, ST_N_TERM, ST_N_WR, ST_N_CHG,
    ST_R_SEL, ST_R_RDA, ST_R_RDB, ST_R_LATB, ST_R_DIFF,
    ST_R_SQX, ST_R_SQY, ST_R_SQZ, ST_R_SQS, ST_R_SQI, ST_R_SQRT,
    ST_R_CHK, ST_R_DIV, ST_R_F,
    ST_R_PX, ST_R_PY, ST_R_PZ, ST_R_PW, ST_R_WRA, ST_R_WRB, ST_R_NEXT,
    ST_E_RD, ST_E_LD
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LD_DT, OP_DT2,
    OP_N_MULG, OP_N_ACC, OP_N_MULT, OP_N_WR, OP_N_CHG,
    OP_LAT_A, OP_LAT_B, OP_DIFF,
    OP_SQX, OP_SQY, OP_SQZ, OP_SQS, OP_SQ_INIT, OP_SQ_STEP,
    OP_DV_INIT, OP_DV_STEP, OP_F,
    OP_PX, OP_PY, OP_PZ, OP_PW, OP_WR_A, OP_WR_B, OP_OUT_LD
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
    logic            row_end;
    logic            last;
  } dp_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic iter_last;
    logic short_len;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/vcgs_if.sv */
// Valid/ready channel interfaces for the tick input and the node result output.
// Self-contained; does not import vcgs_pkg.
`default_nettype none

interface vcgs_tick_if;
  logic        valid;
  logic        ready;
  logic [15:0] step_len;
  modport source (output valid, output step_len, input ready);
  modport sink   (input valid, input step_len, output ready);
endinterface

interface vcgs_node_if;
  logic               valid;
  logic               ready;
  logic [3:0]         node_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               last_node;
  modport source (output valid, output node_index, output pos_x, output pos_y,
                  output pos_z, output last_node, input ready);
  modport sink   (input valid, input node_index, input pos_x, input pos_y,
                  input pos_z, input last_node, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vcgs_dp.sv */
// Datapath: node state memories, shared multiplier, square root and divider
// units, and the result register. Driven by vcgs_ctrl; uses vcgs_pkg.
`default_nettype none

module vcgs_dp import vcgs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic [15:0] step_len_i,
  input  wire logic [23:0] charge_base_i,
  input  wire logic [16:0] charge_ratio_i,
  output logic             node_vld_o,
  input  wire logic        node_rdy_i,
  output node_res_t        node_o
);

  function automatic logic signed [48:0] sx49(input logic signed [31:0] v);
    sx49 = {{17{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = $signed(v[31:0]);
    end
  endfunction

  // p / 65536 rounded to nearest, halves away from zero
  function automatic logic signed [47:0] rnd16(input logic signed [65:0] p);
    logic [65:0] mag;
    logic [65:0] q;
    mag = p[65] ? 66'(-p) : 66'(p);
    q   = (mag + 66'd32768) >> 16;
    rnd16 = p[65] ? -$signed(q[47:0]) : $signed(q[47:0]);
  endfunction

  // node address
  logic [IDX_W-1:0] idx;
  assign idx = IDX_W'(int'(cmd_i.row) * GRID_SIDE + int'(cmd_i.col));

  // node memories with per-entry valid bits
  pos_t cur_mem [NODES];
  pos_t old_mem [NODES];
  logic [NODES-1:0] cur_vld_q, old_vld_q;
  pos_t cur_rd_q, old_rd_q;
  pos_t rst_pos;
  logic cur_we, old_we;
  pos_t cur_wd, old_wd;

  // working registers
  pos_t a_q, o_q, b_q, d_q;
  logic [31:0]        dt2_q;
  logic [23:0]        ch_q, ch_row_q;
  logic [16:0]        ratio_q;
  logic [27:0]        acc_q;
  logic [63:0]        sq_q;
  logic [63:0]        sh_q;
  logic [35:0]        rem_q;
  logic [31:0]        root_q;
  logic [32:0]        den_q;
  logic               neg_q;
  logic [ITR_W-1:0]   cnt_q;
  logic signed [29:0] f_q;
  logic signed [47:0] px_q, py_q, pz_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // derived values
  logic [44:0] acc_sum;
  logic [60:0] term_sum;
  logic [28:0] term;
  logic [40:0] ch_sum;
  logic [23:0] ch_new;
  logic [35:0] sq_rem2, sq_trial, dv_rem2;
  logic        sq_take, dv_take;
  logic [31:0] len_diff;
  logic [48:0] dv_num;
  node_res_t   node_q;
  logic        out_vld_q;

  assign acc_sum  = prod_q[44:0] + 45'd32768;
  assign term_sum = prod_q[60:0] + (61'd1 << 31);
  assign term     = term_sum[60:32];
  assign ch_sum   = prod_q[40:0] + 41'd32768;
  assign ch_new   = ch_sum[39:16];

  assign sq_rem2  = {rem_q[33:0], sh_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_take  = sq_rem2 >= sq_trial;
  assign dv_rem2  = {rem_q[34:0], sh_q[29]};
  assign dv_take  = dv_rem2 >= {3'b000, den_q};

  assign len_diff = (root_q > REST_Q) ? (root_q - REST_Q) : (REST_Q - root_q);
  assign dv_num   = {1'b0, len_diff, 16'h0000} + {17'h00000, root_q};

  // reset grid: x = col * 1.5, y = row * 1.5, z = 0
  always_comb begin
    rst_pos.x = $signed(REST_Q * 32'(cmd_i.col));
    rst_pos.y = $signed(REST_Q * 32'(cmd_i.row));
    rst_pos.z = '0;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_LD_DT: begin
        mul_a = $signed(33'(step_len_i));
        mul_b = $signed(33'(step_len_i));
      end
      OP_N_MULG: begin
        mul_a = $signed(33'(ch_q));
        mul_b = $signed(GRAV_Q);
      end
      OP_N_MULT: begin
        mul_a = $signed(33'(acc_q));
        mul_b = $signed(33'(dt2_q));
      end
      OP_N_WR: begin
        mul_a = $signed(33'(cmd_i.row_end ? ch_row_q : ch_q));
        mul_b = $signed(33'(ratio_q));
      end
      OP_SQX: begin
        mul_a = {d_q.x[31], d_q.x};
        mul_b = {d_q.x[31], d_q.x};
      end
      OP_SQY: begin
        mul_a = {d_q.y[31], d_q.y};
        mul_b = {d_q.y[31], d_q.y};
      end
      OP_SQZ: begin
        mul_a = {d_q.z[31], d_q.z};
        mul_b = {d_q.z[31], d_q.z};
      end
      OP_PX: begin
        mul_a = {d_q.x[31], d_q.x};
        mul_b = {{3{f_q[29]}}, f_q};
      end
      OP_PY: begin
        mul_a = {d_q.y[31], d_q.y};
        mul_b = {{3{f_q[29]}}, f_q};
      end
      OP_PZ: begin
        mul_a = {d_q.z[31], d_q.z};
        mul_b = {{3{f_q[29]}}, f_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // memory write data
  always_comb begin
    cur_we = 1'b0;
    old_we = 1'b0;
    cur_wd = a_q;
    old_wd = a_q;
    case (cmd_i.op)
      OP_N_WR: begin
        cur_we   = 1'b1;
        old_we   = 1'b1;
        cur_wd.x = sat32((sx49(a_q.x) <<< 1) - sx49(o_q.x));
        cur_wd.y = sat32((sx49(a_q.y) <<< 1) - sx49(o_q.y));
        cur_wd.z = sat32((sx49(a_q.z) <<< 1) - sx49(o_q.z) + $signed(49'(term)));
      end
      OP_WR_A: begin
        cur_we   = 1'b1;
        cur_wd.x = sat32(sx49(a_q.x) - 49'(px_q));
        cur_wd.y = sat32(sx49(a_q.y) - 49'(py_q));
        cur_wd.z = sat32(sx49(a_q.z) - 49'(pz_q));
      end
      OP_WR_B: begin
        cur_we   = 1'b1;
        cur_wd.x = sat32(sx49(b_q.x) + 49'(px_q));
        cur_wd.y = sat32(sx49(b_q.y) + 49'(py_q));
        cur_wd.z = sat32(sx49(b_q.z) + 49'(pz_q));
      end
      default: begin
        cur_we = 1'b0;
        old_we = 1'b0;
      end
    endcase
  end

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[idx] <= cur_wd;
    end
    if (old_we) begin
      old_mem[idx] <= old_wd;
    end
    cur_rd_q <= cur_vld_q[idx] ? cur_mem[idx] : rst_pos;
    old_rd_q <= old_vld_q[idx] ? old_mem[idx] : rst_pos;
  end

  // valid bits and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      old_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cur_we) begin
        cur_vld_q[idx] <= 1'b1;
      end
      if (old_we) begin
        old_vld_q[idx] <= 1'b1;
      end
      if (cmd_i.op == OP_OUT_LD) begin
        out_vld_q <= 1'b1;
      end else if (node_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_DT2: begin
        dt2_q    <= prod_q[31:0];
        ch_q     <= charge_base_i;
        ch_row_q <= charge_base_i;
        ratio_q  <= (charge_ratio_i > ONE_Q) ? ONE_Q : charge_ratio_i;
      end
      OP_N_ACC: begin
        acc_q <= acc_sum[43:16];
        a_q   <= cur_rd_q;
        o_q   <= old_rd_q;
      end
      OP_N_CHG: begin
        ch_q <= ch_new;
        if (cmd_i.row_end) begin
          ch_row_q <= ch_new;
        end
      end
      OP_LAT_A: a_q <= cur_rd_q;
      OP_LAT_B: b_q <= cur_rd_q;
      OP_DIFF: begin
        d_q.x <= sat32(sx49(b_q.x) - sx49(a_q.x));
        d_q.y <= sat32(sx49(b_q.y) - sx49(a_q.y));
        d_q.z <= sat32(sx49(b_q.z) - sx49(a_q.z));
      end
      OP_SQY: sq_q <= prod_q[63:0];
      OP_SQZ, OP_SQS: sq_q <= sq_q + prod_q[63:0];
      OP_SQ_INIT: begin
        sh_q   <= sq_q;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= ITR_W'(SQ_STEPS - 1);
      end
      OP_SQ_STEP: begin
        sh_q   <= {sh_q[61:0], 2'b00};
        rem_q  <= sq_take ? (sq_rem2 - sq_trial) : sq_rem2;
        root_q <= {root_q[30:0], sq_take};
        cnt_q  <= cnt_q - 1'b1;
      end
      OP_DV_INIT: begin
        rem_q <= 36'(dv_num[48:30]);
        sh_q  <= 64'(dv_num[29:0]);
        den_q <= {root_q, 1'b0};
        neg_q <= root_q > REST_Q;
        cnt_q <= ITR_W'(DV_STEPS - 1);
      end
      OP_DV_STEP: begin
        rem_q      <= dv_take ? (dv_rem2 - {3'b000, den_q}) : dv_rem2;
        sh_q[29:0] <= {sh_q[28:0], dv_take};
        cnt_q      <= cnt_q - 1'b1;
      end
      OP_F: f_q <= neg_q ? -$signed(sh_q[29:0]) : $signed(sh_q[29:0]);
      OP_PY: px_q <= rnd16(prod_q);
      OP_PZ: py_q <= rnd16(prod_q);
      OP_PW: pz_q <= rnd16(prod_q);
      OP_OUT_LD: begin
        node_q.node_index <= 4'(idx);
        node_q.pos_x      <= cur_rd_q.x;
        node_q.pos_y      <= cur_rd_q.y;
        node_q.pos_z      <= cur_rd_q.z;
        node_q.last_node  <= cmd_i.last;
      end
      default: begin
      end
    endcase
    if (cmd_i.op == OP_N_WR) begin
      acc_q <= acc_q;
    end
  end

  assign sts_o.dt_zero   = step_len_i == 16'h0000;
  assign sts_o.iter_last = cnt_q == '0;
  assign sts_o.short_len = root_q <= DIST_MIN_Q;
  assign sts_o.out_free  = !out_vld_q || node_rdy_i;
  assign node_vld_o      = out_vld_q;
  assign node_o          = node_q;

endmodule

`default_nettype wire

/* hw/rtl/vcgs_ctrl.sv */
// Controller: sequences integration, spring relaxation and result emission.
// Issues one datapath command per cycle; uses vcgs_pkg.
`default_nettype none

module vcgs_ctrl import vcgs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    tick_vld_i,
  output logic         tick_rdy_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [RC_W-1:0] LAST_RC = RC_W'(GRID_SIDE - 1);

  ctrl_state_e     state_q, state_d;
  logic [RC_W-1:0] row_q, row_d, col_q, col_d;
  logic            dir_q, dir_d;   // 0: right spring, 1: down spring
  logic            col_last, row_last, node_last, spring_ok;

  assign col_last  = col_q == LAST_RC;
  assign row_last  = row_q == LAST_RC;
  assign node_last = col_last && row_last;
  assign spring_ok = dir_q ? !row_last : !col_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      dir_q   <= dir_d;
    end
  end

  // next state and node walk
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    dir_d   = dir_q;
    unique case (state_q)
      ST_IDLE: begin
        row_d = '0;
        col_d = '0;
        dir_d = 1'b0;
        if (tick_vld_i) begin
          state_d = sts_i.dt_zero ? ST_E_RD : ST_DT2;
        end
      end
      ST_DT2:    state_d = ST_N_RD;
      ST_N_RD:   state_d = ST_N_ACC;
      ST_N_ACC:  state_d = ST_N_TERM;
      ST_N_TERM: state_d = ST_N_WR;
      ST_N_WR:   state_d = ST_N_CHG;
      ST_N_CHG: begin
        state_d = node_last ? ST_R_SEL : ST_N_RD;
        if (col_last) begin
          col_d = '0;
          row_d = row_last ? '0 : row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_R_SEL:  state_d = spring_ok ? ST_R_RDA : ST_R_NEXT;
      ST_R_RDA:  state_d = ST_R_RDB;
      ST_R_RDB:  state_d = ST_R_LATB;
      ST_R_LATB: state_d = ST_R_DIFF;
      ST_R_DIFF: state_d = ST_R_SQX;
      ST_R_SQX:  state_d = ST_R_SQY;
      ST_R_SQY:  state_d = ST_R_SQZ;
      ST_R_SQZ:  state_d = ST_R_SQS;
      ST_R_SQS:  state_d = ST_R_SQI;
      ST_R_SQI:  state_d = ST_R_SQRT;
      ST_R_SQRT: state_d = sts_i.iter_last ? ST_R_CHK : ST_R_SQRT;
      ST_R_CHK:  state_d = sts_i.short_len ? ST_R_NEXT : ST_R_DIV;
      ST_R_DIV:  state_d = sts_i.iter_last ? ST_R_F : ST_R_DIV;
      ST_R_F:    state_d = ST_R_PX;
      ST_R_PX:   state_d = ST_R_PY;
      ST_R_PY:   state_d = ST_R_PZ;
      ST_R_PZ:   state_d = ST_R_PW;
      ST_R_PW:   state_d = ST_R_WRA;
      ST_R_WRA:  state_d = ST_R_WRB;
      ST_R_WRB:  state_d = ST_R_NEXT;
      ST_R_NEXT: begin
        if (!dir_q) begin
          dir_d   = 1'b1;
          state_d = ST_R_SEL;
        end else begin
          dir_d   = 1'b0;
          state_d = node_last ? ST_E_RD : ST_R_SEL;
          if (col_last) begin
            col_d = '0;
            row_d = row_last ? '0 : row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_E_RD: state_d = ST_E_LD;
      ST_E_LD: begin
        if (sts_i.out_free) begin
          state_d = node_last ? ST_IDLE : ST_E_RD;
          if (col_last) begin
            col_d = '0;
            row_d = row_last ? '0 : row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    tick_rdy_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.row     = row_q;
    cmd_o.col     = col_q;
    cmd_o.row_end = col_last;
    cmd_o.last    = node_last;
    unique case (state_q)
      ST_IDLE: begin
        tick_rdy_o = 1'b1;
        cmd_o.op   = tick_vld_i ? OP_LD_DT : OP_NONE;
      end
      ST_DT2:    cmd_o.op = OP_DT2;
      ST_N_RD:   cmd_o.op = OP_N_MULG;
      ST_N_ACC:  cmd_o.op = OP_N_ACC;
      ST_N_TERM: cmd_o.op = OP_N_MULT;
      ST_N_WR:   cmd_o.op = OP_N_WR;
      ST_N_CHG:  cmd_o.op = OP_N_CHG;
      ST_R_RDB, ST_R_WRB: begin
        cmd_o.op  = (state_q == ST_R_RDB) ? OP_LAT_A : OP_WR_B;
        cmd_o.row = dir_q ? row_q + 1'b1 : row_q;
        cmd_o.col = dir_q ? col_q : col_q + 1'b1;
      end
      ST_R_LATB: cmd_o.op = OP_LAT_B;
      ST_R_DIFF: cmd_o.op = OP_DIFF;
      ST_R_SQX:  cmd_o.op = OP_SQX;
      ST_R_SQY:  cmd_o.op = OP_SQY;
      ST_R_SQZ:  cmd_o.op = OP_SQZ;
      ST_R_SQS:  cmd_o.op = OP_SQS;
      ST_R_SQI:  cmd_o.op = OP_SQ_INIT;
      ST_R_SQRT: cmd_o.op = OP_SQ_STEP;
      ST_R_CHK:  cmd_o.op = OP_DV_INIT;
      ST_R_DIV:  cmd_o.op = OP_DV_STEP;
      ST_R_F:    cmd_o.op = OP_F;
      ST_R_PX:   cmd_o.op = OP_PX;
      ST_R_PY:   cmd_o.op = OP_PY;
      ST_R_PZ:   cmd_o.op = OP_PZ;
      ST_R_PW:   cmd_o.op = OP_PW;
      ST_R_WRA:  cmd_o.op = OP_WR_A;
      ST_E_LD:   cmd_o.op = sts_i.out_free ? OP_OUT_LD : OP_NONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/verlet_cloth_grid_step.sv */
// Top level of the Verlet cloth grid stepper: APB register file, controller
// and datapath. Depends on vcgs_pkg, vcgs_if, vcgs_ctrl and vcgs_dp.
//
//   channel  | dir | transfer                 | payload
//   tick_i   | in  | valid & ready            | step_len (Q0.16)
//   node_o   | out | valid & ready            | node_index, pos_x/y/z, last_node
//   apb      | in  | psel & penable & pwrite  | charge_base, charge_ratio
//
// One tick at a time. Integration visits each node once; each spring takes a
// square root of 32 steps and, when it is relaxed, a division of 30 steps; a
// missing edge spring is skipped. A 4x4 grid has 24 springs, and each node is
// then emitted in turn.
// A zero time step goes straight to emission.
// Reset restores the rest grid through per-node valid bits, with no sweep.
// A stalled output holds the emission walk; ready on tick_i is low until the
// last node has been loaded into the output register.
`default_nettype none

module verlet_cloth_grid_step import vcgs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  vcgs_tick_if.sink        tick_i,
  vcgs_node_if.source      node_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [23:0] charge_base_q;
  logic [16:0] charge_ratio_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  node_res_t   node_res;

  // register file
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_base_q  <= 24'(ONE_Q);
      charge_ratio_q <= ONE_Q;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CHARGE_BASE:  charge_base_q  <= pwdata[23:0];
        REG_CHARGE_RATIO: charge_ratio_q <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHARGE_BASE:  prdata = 32'(charge_base_q);
      REG_CHARGE_RATIO: prdata = 32'(charge_ratio_q);
      default:          prdata = '0;
    endcase
  end

  vcgs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_vld_i (tick_i.valid),
    .tick_rdy_o (tick_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vcgs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .step_len_i     (tick_i.step_len),
    .charge_base_i  (charge_base_q),
    .charge_ratio_i (charge_ratio_q),
    .node_vld_o     (node_o.valid),
    .node_rdy_i     (node_o.ready),
    .node_o         (node_res)
  );

  assign node_o.node_index = node_res.node_index;
  assign node_o.pos_x      = node_res.pos_x;
  assign node_o.pos_y      = node_res.pos_y;
  assign node_o.pos_z      = node_res.pos_z;
  assign node_o.last_node  = node_res.last_node;

  // a tick starts work, so the input closes right after a transfer
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i.valid && tick_i.ready |=> !tick_i.ready)
    else $error("tick input still open after a transfer");

  // the flagged result is the final node of the grid
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_o.valid && node_o.last_node |-> node_o.node_index == 4'(NODES - 1))
    else $error("last_node on a node other than the final one");

  // while a non-final result waits, no new tick is taken
  a_no_tick_mid_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_o.valid && !node_o.last_node |-> !tick_i.ready)
    else $error("tick input open during emission");

endmodule

`default_nettype wire
